/* hw/rtl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property body, masked while in reset
`define WPC_CLK_PROP(p) @(posedge clk) disable iff (!rst_n) (p)

// labelled concurrent assertion reporting through $error
`define WPC_ASSERT(lbl, p, msg) \
  lbl: assert property (`WPC_CLK_PROP(p)) else $error(msg);

`endif

/* hw/rtl/wpc_pkg.sv */
// shared constants and types of the window peak counter
`default_nettype none

package wpc_pkg;

  // default sizing of the block
  localparam int WPC_WINDOW_MAX  = 1024;
  localparam int WPC_STREAM_MAX  = 65536;
  localparam int WPC_SAMPLE_BITS = 32;

  // width of the window length register and of the peak counters
  localparam int CNT_W = 11;

  // shortest usable window and counter ceiling
  localparam logic [CNT_W-1:0] K_MIN  = 11'd3;
  localparam logic [CNT_W-1:0] RC_MAX = 11'h7FF;

  // status from the update core to the ring control
  typedef struct packed {
    logic active;   // word lies within the kept part of the stream
    logic peak_we;  // a peak flag is written for this word
    logic is_peak;  // value of that flag
  } wpc_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/wpc_ring.sv */
// ring memory of peak flags, one write and one registered read per cycle
`default_nettype none

module wpc_ring #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic          wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic               rdata
);

  logic mem [DEPTH];
  logic rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* hw/rtl/wpc_core.sv */
// per-word update of peak count, best window and stream position
`default_nettype none

module wpc_core
  import wpc_pkg::*;
#(
  parameter int STREAM_MAX  = WPC_STREAM_MAX,
  parameter int SAMPLE_BITS = WPC_SAMPLE_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        go,
  input  wire logic [SAMPLE_BITS-1:0]      sample,
  input  wire logic                        last,
  input  wire logic [CNT_W-1:0]            k_eff,
  input  wire logic                        leave_flag,
  output wpc_stat_t                        stat,
  output logic [CNT_W-1:0]                 res_parts,
  output logic [$clog2(STREAM_MAX):0]      res_start,
  output logic                             res_short
);

  localparam int POS_W = $clog2(STREAM_MAX + 1);
  localparam int BI_W  = $clog2(STREAM_MAX);
  localparam int BS_W  = BI_W + 1;
  localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;
  localparam logic [SAMPLE_BITS-1:0] SIGN_BIT = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic [SAMPLE_BITS-1:0] prev_r, prev_nxt;
  logic [SAMPLE_BITS-1:0] pprev_r, pprev_nxt;
  logic [CNT_W-1:0]       rc_r, rc_nxt;
  logic [CNT_W-1:0]       best_r, best_nxt;
  logic [BI_W-1:0]        bidx_r, bidx_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;

  logic [SAMPLE_BITS-1:0] key;
  logic [CMP_W-1:0]       j_x, k_x, jp1_x;
  logic                   active, peak_we, is_peak, rc_dec;
  logic [CNT_W-1:0]       rc_a, rc_b, best_a;
  logic [BI_W-1:0]        bidx_a;
  logic [POS_W-1:0]       pos_a;

  // order-preserving key and peak test
  assign key     = sample ^ SIGN_BIT;
  assign j_x     = CMP_W'(pos_r);
  assign k_x     = CMP_W'(k_eff);
  assign jp1_x   = j_x + CMP_W'(1);
  assign active  = (pos_r < POS_W'(STREAM_MAX));
  assign peak_we = active && (j_x >= CMP_W'(2));
  assign is_peak = (prev_r > pprev_r) && (prev_r > key);

  // window count: drop the leaving flag, add the new one, saturating
  assign rc_dec = peak_we && (j_x >= k_x) && leave_flag && (rc_r != '0);
  assign rc_a   = rc_dec ? rc_r - CNT_W'(1) : rc_r;
  assign rc_b   = (peak_we && is_peak && (rc_a != RC_MAX)) ? rc_a + CNT_W'(1) : rc_a;

  // best window, earliest kept on ties
  always_comb begin
    best_a = best_r;
    bidx_a = bidx_r;
    if (active) begin
      if (jp1_x == k_x) begin
        best_a = rc_b;
        bidx_a = '0;
      end else if ((jp1_x > k_x) && (rc_b > best_r)) begin
        best_a = rc_b;
        bidx_a = BI_W'(j_x - k_x + CMP_W'(1));
      end
    end
  end

  assign pos_a = active ? pos_r + POS_W'(1) : pos_r;

  // result for a closing word
  always_comb begin
    res_short = (CMP_W'(pos_a) < k_x);
    if (res_short) begin
      res_parts = CNT_W'(1);
      res_start = BS_W'(1);
    end else begin
      res_parts = best_a + CNT_W'(1);
      res_start = BS_W'(bidx_a) + BS_W'(1);
    end
  end

  // next state: advance, or clear after the closing word
  always_comb begin
    prev_nxt  = prev_r;
    pprev_nxt = pprev_r;
    rc_nxt    = rc_r;
    best_nxt  = best_r;
    bidx_nxt  = bidx_r;
    pos_nxt   = pos_r;
    if (go) begin
      if (last) begin
        prev_nxt  = '0;
        pprev_nxt = '0;
        rc_nxt    = '0;
        best_nxt  = '0;
        bidx_nxt  = '0;
        pos_nxt   = '0;
      end else begin
        if (active) begin
          prev_nxt  = key;
          pprev_nxt = prev_r;
          rc_nxt    = rc_b;
        end
        best_nxt = best_a;
        bidx_nxt = bidx_a;
        pos_nxt  = pos_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      pprev_r <= '0;
      rc_r    <= '0;
      best_r  <= '0;
      bidx_r  <= '0;
      pos_r   <= '0;
    end else begin
      prev_r  <= prev_nxt;
      pprev_r <= pprev_nxt;
      rc_r    <= rc_nxt;
      best_r  <= best_nxt;
      bidx_r  <= bidx_nxt;
      pos_r   <= pos_nxt;
    end
  end

  assign stat.active  = active;
  assign stat.peak_we = peak_we;
  assign stat.is_peak = is_peak;

endmodule

`default_nettype wire

/* hw/rtl/window_peak_count_max_unit.sv */
// top level of the sliding-window peak counter
// Takes one signed sample word per cycle unless the input stalls; a word can be
// accepted in the cycle after the previous one with no gap. Each word is held in an
// input register while its leaving peak flag is read from the flag ring, then updates
// the counters; the result of a stream is loaded into the output register when its
// last word leaves the input register. The flag ring is a single memory of
// WINDOW_MAX bits with one write and one read each cycle; a flag written by one word
// and read by the next is forwarded around it. The input stalls only when a last
// word finds the output register full and stalled. No clearing pass is needed after
// reset: flags are read only after being written in the same stream.
`default_nettype none

module window_peak_count_max_unit
  import wpc_pkg::*;
#(
  parameter int WINDOW_MAX  = WPC_WINDOW_MAX,
  parameter int STREAM_MAX  = WPC_STREAM_MAX,
  parameter int SAMPLE_BITS = WPC_SAMPLE_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [CNT_W-1:0]              cfg_window_len,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
  input  wire logic                          in_last,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [CNT_W-1:0]                   out_parts,
  output logic [$clog2(STREAM_MAX):0]        out_best_start,
  output logic                               out_too_short
);

  localparam int AW   = $clog2(WINDOW_MAX);
  localparam int BS_W = $clog2(STREAM_MAX) + 1;
  localparam int LW   = ((AW > CNT_W) ? AW : CNT_W) + 1;

  logic [CNT_W-1:0]       window_len_r;
  logic [CNT_W-1:0]       k_eff;

  logic                   s1_valid_r, s1_valid_nxt;
  logic [SAMPLE_BITS-1:0] s1_sample_r;
  logic                   s1_last_r;
  logic                   accept, go;

  logic [AW-1:0]          rp_r, rp_nxt, rp_step, wr_addr, leave_in;
  logic [LW-1:0]          rp_x, km1_x, leave_x;
  logic                   fwd_r, fwd_val_r, rd_flag, leave_flag;

  wpc_stat_t              stat;
  logic [CNT_W-1:0]       res_parts;
  logic [BS_W-1:0]        res_start;
  logic                   res_short;

  logic                   out_valid_r;
  logic [CNT_W-1:0]       out_parts_r;
  logic [BS_W-1:0]        out_start_r;
  logic                   out_short_r;

  // window length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r <= K_MIN;
    end else if (cfg_we) begin
      window_len_r <= cfg_window_len;
    end
  end

  // clamp the window length to the usable range
  always_comb begin
    if (window_len_r < K_MIN) begin
      k_eff = K_MIN;
    end else if (32'(window_len_r) > 32'(WINDOW_MAX)) begin
      k_eff = CNT_W'(WINDOW_MAX);
    end else begin
      k_eff = window_len_r;
    end
  end

  // handshake: a closing word waits only for a free output slot
  assign go       = s1_valid_r && (!s1_last_r || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !go;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // input word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample_r <= in_sample;
      s1_last_r   <= in_last;
    end
  end

  // ring pointer: slot of the current position
  assign wr_addr = (rp_r == '0) ? AW'(WINDOW_MAX - 1) : rp_r - AW'(1);
  assign rp_step = (rp_r == AW'(WINDOW_MAX - 1)) ? '0 : rp_r + AW'(1);

  always_comb begin
    rp_nxt = rp_r;
    if (go) begin
      if (s1_last_r) begin
        rp_nxt = '0;
      end else if (stat.active) begin
        rp_nxt = rp_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r <= '0;
    end else begin
      rp_r <= rp_nxt;
    end
  end

  // slot of the flag leaving the window of the incoming word
  assign rp_x     = LW'(rp_nxt);
  assign km1_x    = LW'(k_eff) - LW'(1);
  assign leave_x  = (rp_x >= km1_x) ? rp_x - km1_x : rp_x + LW'(WINDOW_MAX) - km1_x;
  assign leave_in = leave_x[AW-1:0];

  wpc_ring #(
    .DEPTH (WINDOW_MAX),
    .AW    (AW)
  ) u_ring (
    .clk   (clk),
    .we    (go && stat.peak_we),
    .waddr (wr_addr),
    .wdata (stat.is_peak),
    .re    (accept),
    .raddr (leave_in),
    .rdata (rd_flag)
  );

  // forward a flag written in the same cycle it is read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (accept) begin
      fwd_r <= go && stat.peak_we && (leave_in == wr_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_val_r <= stat.is_peak;
    end
  end

  assign leave_flag = fwd_r ? fwd_val_r : rd_flag;

  wpc_core #(
    .STREAM_MAX  (STREAM_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (go),
    .sample     (s1_sample_r),
    .last       (s1_last_r),
    .k_eff      (k_eff),
    .leave_flag (leave_flag),
    .stat       (stat),
    .res_parts  (res_parts),
    .res_start  (res_start),
    .res_short  (res_short)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && s1_last_r) begin
      out_parts_r <= res_parts;
      out_start_r <= res_start;
      out_short_r <= res_short;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_parts      = out_parts_r;
  assign out_best_start = out_start_r;
  assign out_too_short  = out_short_r;

endmodule

`default_nettype wire

/* hw/rtl/wpc_checker.sv */
// port-level checks of the peak counter, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module wpc_checker
  import wpc_pkg::*;
#(
  parameter int STREAM_MAX  = WPC_STREAM_MAX
) (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          in_last,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [CNT_W-1:0]              out_parts,
  input wire logic [$clog2(STREAM_MAX):0]   out_best_start,
  input wire logic                          out_too_short
);

  logic [CNT_W+$clog2(STREAM_MAX)+1:0] out_word;
  logic                                last_take;

  assign out_word  = {out_parts, out_best_start, out_too_short};
  assign last_take = in_valid && !in_stall && in_last;

  // a stalled result word holds
  `WPC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_word), "stalled word changed")

  // a fresh result follows an accepted closing word
  `WPC_ASSERT(a_out_after_last, $rose(out_valid) |-> $past(last_take, 2), "stray result word")

  // a short stream reports one part from the first sample
  `WPC_ASSERT(a_short_fields, out_valid && out_too_short |-> out_parts == 1 && out_best_start == 1, "bad short result")

  // window starts are one-based
  `WPC_ASSERT(a_start_nonzero, out_valid |-> out_best_start != 0, "zero window start")

endmodule

bind window_peak_count_max_unit wpc_checker #(
  .STREAM_MAX  (STREAM_MAX)
) u_wpc_checker (.*);

`default_nettype wire
